@@ hdl/clbf_pkg.sv @@
// ----------------------------------------------------------------------------
// clbf_pkg
// Shared constants, codes and types of the cell list bond finder.
// ----------------------------------------------------------------------------
`default_nettype none

package clbf_pkg;

    localparam int MAX_ATOMS    = 1024;
    localparam int AIDX_W       = $clog2(MAX_ATOMS);
    localparam int ACNT_W       = AIDX_W + 1;
    localparam int MAX_CELLS    = 4096;
    localparam int CELL_W       = $clog2(MAX_CELLS);
    localparam int CADR_W       = CELL_W + 1;
    localparam int DIM_W        = CELL_W + 1;
    localparam int MAX_PARTNERS = 16;
    localparam int PCNT_W       = $clog2(MAX_PARTNERS + 1);
    localparam int COORD_BITS   = 24;
    localparam int TOL_W        = 23;
    localparam int BODY_W       = 16;
    localparam int OP_W         = 2;
    localparam int ST_W         = 3;
    localparam int TOL_RESET    = 256;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR = 2'd0,
        OP_LOAD  = 2'd1,
        OP_BUILD = 2'd2,
        OP_QUERY = 2'd3
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_GRID     = 3'd2,
        ST_NOTBUILT = 3'd3,
        ST_BADIDX   = 3'd4,
        ST_TRUNC    = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        PH_DIMS,
        PH_CNT,
        PH_QRY
    } t_phase;

    typedef enum logic [5:0] {
        S_IDLE,
        S_EMPTY,
        S_EMIT,
        S_BB_RD,
        S_BB_CMP,
        S_DIV,
        S_DIV_DONE,
        S_TOT1,
        S_TOT2,
        S_CLEAR,
        S_CNT_RD,
        S_CNT_CAP,
        S_H1,
        S_H2,
        S_CNT_RD2,
        S_CNT_WR,
        S_PFX_RD,
        S_PFX_WR,
        S_FIL_RD,
        S_FIL_FC,
        S_FIL_WR,
        S_Q_RD,
        S_Q_CAP,
        S_Q_T2,
        S_Q_CELL,
        S_Q_NEXT,
        S_Q_CS,
        S_Q_CSD,
        S_Q_SCAN,
        S_Q_SRT,
        S_Q_ATM,
        S_Q_D0,
        S_Q_D1,
        S_Q_D2,
        S_Q_CHK,
        S_Q_END
    } t_state;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
        logic        [BODY_W-1:0]     body;
    } t_atom;

endpackage

`default_nettype wire

@@ hdl/clbf_if.sv @@
// ----------------------------------------------------------------------------
// clbf_in_if / clbf_res_if
// Valid/ready channels for command beats and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface clbf_in_if;
    logic                                     valid;
    logic                                     ready;
    logic [clbf_pkg::OP_W-1:0]                opcode;
    logic signed [clbf_pkg::COORD_BITS-1:0]   x_coord;
    logic signed [clbf_pkg::COORD_BITS-1:0]   y_coord;
    logic signed [clbf_pkg::COORD_BITS-1:0]   z_coord;
    logic [clbf_pkg::BODY_W-1:0]              body_id;
    logic [clbf_pkg::AIDX_W-1:0]              atom_index;

    modport source (output valid, opcode, x_coord, y_coord, z_coord, body_id, atom_index,
                    input ready);
    modport sink   (input valid, opcode, x_coord, y_coord, z_coord, body_id, atom_index,
                    output ready);
endinterface

interface clbf_res_if;
    logic                          valid;
    logic                          ready;
    logic [clbf_pkg::ST_W-1:0]     status;
    logic [clbf_pkg::AIDX_W-1:0]   partner_index;
    logic                          has_partner;
    logic                          last;

    modport source (output valid, status, partner_index, has_partner, last, input ready);
    modport sink   (input valid, status, partner_index, has_partner, last, output ready);
endinterface

`default_nettype wire

@@ hdl/cell_list_bond_finder_unit.sv @@
// ----------------------------------------------------------------------------
// cell_list_bond_finder_unit
// Bond search over a uniform cell grid held in on-chip memories.
// ----------------------------------------------------------------------------
// Commands arrive as beats on i_in; results leave as beats on o_res, the
// final beat of each command flagged by last. One command is worked at a
// time; i_in.ready is high only while the sequencer is idle and the output
// register is free or being drained.
// Clear and load: one result, registered in the cycle after the command beat.
// Build: a pass over the atoms for the bounding box, three serial divides for
//   the grid size, a pass to clear the cell table, binning of the atoms (three
//   24-step serial divides per atom), the prefix sum and a scatter of the
//   indices. The serial divider takes most of the build time.
// Query: three serial divides for the home cell, then each neighbor cell is
//   checked against the grid and, when inside it, its atoms are read; an atom
//   of the same body with a higher index gets the distance check (one atom
//   memory port, squares summed one axis at a time). At most 27 cells are visited.
// When o_res is stalled the sequencer holds before each result beat.
// Reset clears control state only; the atom, cell and index memories need
// no clearing pass, since only entries written by load and build are read.
// A write on the configuration port sets the tolerance and drops the grid.
// ----------------------------------------------------------------------------
`default_nettype none

module cell_list_bond_finder_unit (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [clbf_pkg::TOL_W-1:0]  i_cfg_wdata,
    clbf_in_if.sink                          i_in,
    clbf_res_if.source                       o_res
);
    import clbf_pkg::*;

    localparam int DIV_STEPS = COORD_BITS;
    localparam int DC_W      = $clog2(DIV_STEPS + 1);
    localparam int PROD_W    = 2 * DIM_W;
    localparam int HASH_W    = DIM_W + PROD_W;
    localparam int DIFF_W    = COORD_BITS + 1;
    localparam int SQ_W      = 2 * DIFF_W + 2;
    localparam int CC_W      = CELL_W + 2;

    // memories
    t_atom             atom_mem [MAX_ATOMS];
    logic [CELL_W-1:0] cid_mem  [MAX_ATOMS];
    logic [ACNT_W-1:0] cs_mem   [MAX_CELLS+1];
    logic [ACNT_W-1:0] fc_mem   [MAX_CELLS];
    logic [AIDX_W-1:0] srt_mem  [MAX_ATOMS];

    t_atom             am_q;
    logic [CELL_W-1:0] cid_q;
    logic [ACNT_W-1:0] cs_qa, cs_qb, fc_q;
    logic [AIDX_W-1:0] srt_q;

    logic              am_we, cid_we, cs_we, fc_we, srt_we;
    logic [AIDX_W-1:0] am_ra;
    t_atom             am_wd;
    logic [CADR_W-1:0] cs_ra, cs_wa;
    logic [ACNT_W-1:0] cs_wd, fc_wd;
    logic [CELL_W-1:0] fc_wa;

    // control and datapath registers
    t_state              r_state, n_state;
    t_phase              r_phase, n_phase;
    logic [TOL_W-1:0]    r_tol, n_tol;
    logic [ACNT_W-1:0]   r_n, n_n;
    logic                r_built, n_built;
    logic [1:0]          r_axis, n_axis;
    logic [ACNT_W-1:0]   r_i, n_i;
    logic [CADR_W-1:0]   r_pk, n_pk;
    logic [CADR_W-1:0]   r_total, n_total;
    logic [ACNT_W-1:0]   r_acc, n_acc;
    logic [DC_W-1:0]     r_dc, n_dc;
    logic [COORD_BITS-1:0] r_dq, n_dq;
    logic [TOL_W-1:0]    r_dr, n_dr;
    logic [ST_W-1:0]     r_st, n_st;
    logic [PROD_W-1:0]   r_prod, n_prod;
    logic [CELL_W-1:0]   r_h, n_h;
    logic [AIDX_W-1:0]   r_qi, n_qi;
    logic [BODY_W-1:0]   r_qbody, n_qbody;
    logic [AIDX_W-1:0]   r_j, n_j;
    logic [ACNT_W-1:0]   r_k, n_k, r_kend, n_kend;
    logic [2*TOL_W-1:0]  r_t2, n_t2;
    logic [SQ_W-1:0]     r_ds, n_ds;
    logic [PCNT_W-1:0]   r_pcnt, n_pcnt;
    logic                r_pv, n_pv;
    logic [AIDX_W-1:0]   r_pidx, n_pidx;

    logic signed [COORD_BITS-1:0] r_lo [3], n_lo [3];
    logic signed [COORD_BITS-1:0] r_hi [3], n_hi [3];
    logic signed [COORD_BITS-1:0] r_min [3], n_min [3];
    logic signed [COORD_BITS-1:0] r_pos [3], n_pos [3];
    logic [DIM_W-1:0]    r_dim [3], n_dim [3];
    logic [CELL_W-1:0]   r_cell [3], n_cell [3];
    logic [CELL_W-1:0]   r_base [3], n_base [3];
    logic [DIFF_W-1:0]   r_e [3], n_e [3];
    logic [1:0]          r_d [3], n_d [3];

    // output register
    logic                r_ov, n_ov;
    logic [ST_W-1:0]     r_ost, n_ost;
    logic [AIDX_W-1:0]   r_oidx, n_oidx;
    logic                r_ohp, n_ohp, r_olast, n_olast;

    logic out_free;
    assign out_free = !r_ov || o_res.ready;

    assign i_in.ready          = (r_state == S_IDLE) && out_free;
    assign o_res.valid         = r_ov;
    assign o_res.status        = r_ost;
    assign o_res.partner_index = r_oidx;
    assign o_res.has_partner   = r_ohp;
    assign o_res.last          = r_olast;

    logic [TOL_W-1:0]      t_eff;
    logic [COORD_BITS-1:0] dvd;
    logic [COORD_BITS:0]   d_tmp, d_sub;
    logic                  d_ge;
    logic [HASH_W-1:0]     hash;
    logic [PROD_W+DIM_W-1:0] tot;
    logic signed [CC_W-1:0] qc [3];
    logic                  qc_ok;
    logic signed [DIFF_W-1:0] ed [3];

    always_comb begin
        t_eff = (r_tol == '0) ? TOL_W'(1) : r_tol;
        if (r_phase == PH_DIMS) begin
            dvd = COORD_BITS'(r_hi[r_axis] - r_lo[r_axis]);
        end else begin
            dvd = COORD_BITS'(r_pos[r_axis] - r_min[r_axis]);
        end
        d_tmp = {1'b0, r_dr, r_dq[COORD_BITS-1]};
        d_ge  = d_tmp >= {2'b00, t_eff};
        d_sub = d_tmp - {2'b00, t_eff};
        hash  = HASH_W'(r_cell[0]) + HASH_W'(r_dim[0]) * HASH_W'(r_prod);
        tot   = (PROD_W+DIM_W)'(r_prod) * (PROD_W+DIM_W)'(r_dim[2]);
        qc_ok = 1'b1;
        for (int a = 0; a < 3; a++) begin
            qc[a] = $signed({2'b00, r_base[a]}) + $signed({{CELL_W{1'b0}}, r_d[a]})
                    - CC_W'(1);
            if (qc[a] < 0 || qc[a] >= $signed({1'b0, r_dim[a]})) qc_ok = 1'b0;
            ed[a] = DIFF_W'(am_q.x) - DIFF_W'(r_pos[a]);
        end
        ed[0] = $signed({am_q.x[COORD_BITS-1], am_q.x}) - $signed({r_pos[0][COORD_BITS-1], r_pos[0]});
        ed[1] = $signed({am_q.y[COORD_BITS-1], am_q.y}) - $signed({r_pos[1][COORD_BITS-1], r_pos[1]});
        ed[2] = $signed({am_q.z[COORD_BITS-1], am_q.z}) - $signed({r_pos[2][COORD_BITS-1], r_pos[2]});
    end

    always_comb begin
        n_state = r_state;  n_phase = r_phase;  n_tol = r_tol;  n_n = r_n;
        n_built = r_built;  n_axis = r_axis;    n_i = r_i;      n_pk = r_pk;
        n_total = r_total;  n_acc = r_acc;      n_dc = r_dc;    n_dq = r_dq;
        n_dr = r_dr;        n_st = r_st;        n_prod = r_prod; n_h = r_h;
        n_qi = r_qi;        n_qbody = r_qbody;  n_j = r_j;      n_k = r_k;
        n_kend = r_kend;    n_t2 = r_t2;        n_ds = r_ds;    n_pcnt = r_pcnt;
        n_pv = r_pv;        n_pidx = r_pidx;
        n_lo = r_lo;  n_hi = r_hi;  n_min = r_min;  n_pos = r_pos;  n_dim = r_dim;
        n_cell = r_cell;  n_base = r_base;  n_e = r_e;  n_d = r_d;
        n_ov = r_ov && !o_res.ready;
        n_ost = r_ost;  n_oidx = r_oidx;  n_ohp = r_ohp;  n_olast = r_olast;

        am_we = 1'b0;  am_ra = r_i[AIDX_W-1:0];
        am_wd = '{x: i_in.x_coord, y: i_in.y_coord, z: i_in.z_coord, body: i_in.body_id};
        cid_we = 1'b0;  cs_we = 1'b0;  fc_we = 1'b0;  srt_we = 1'b0;
        cs_ra = r_pk;  cs_wa = r_pk;  cs_wd = '0;
        fc_wa = r_h;   fc_wd = fc_q + ACNT_W'(1);

        case (r_state)
            S_IDLE: begin
                if (i_in.valid && out_free) begin
                    n_ov = 1'b1;  n_oidx = '0;  n_ohp = 1'b0;  n_olast = 1'b1;
                    n_ost = ST_OK;
                    case (t_op'(i_in.opcode))
                        OP_CLEAR: begin
                            n_n = '0;  n_built = 1'b0;
                        end
                        OP_LOAD: begin
                            n_built = 1'b0;
                            if (r_n >= ACNT_W'(MAX_ATOMS)) begin
                                n_ost = ST_FULL;
                            end else begin
                                am_we = 1'b1;
                                n_n = r_n + ACNT_W'(1);
                            end
                        end
                        OP_BUILD: begin
                            n_ov = 1'b0;  n_built = 1'b0;  n_st = ST_OK;
                            if (r_n == '0) begin
                                for (int a = 0; a < 3; a++) begin
                                    n_min[a] = '0;  n_dim[a] = DIM_W'(1);
                                end
                                cs_we = 1'b1;  cs_wa = '0;
                                n_state = S_EMPTY;
                            end else begin
                                n_i = '0;
                                n_state = S_BB_RD;
                            end
                        end
                        default: begin
                            if (!r_built) begin
                                n_ost = ST_NOTBUILT;
                            end else if ({1'b0, i_in.atom_index} >= r_n) begin
                                n_ost = ST_BADIDX;
                            end else begin
                                n_ov = 1'b0;
                                n_qi = i_in.atom_index;
                                n_state = S_Q_RD;
                            end
                        end
                    endcase
                end
            end
            S_EMPTY: begin
                cs_we = 1'b1;  cs_wa = CADR_W'(1);
                n_built = 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_ov = 1'b1;  n_ost = r_st;  n_oidx = '0;  n_ohp = 1'b0;  n_olast = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_BB_RD: begin
                n_state = S_BB_CMP;
            end
            S_BB_CMP: begin
                n_pos[0] = am_q.x;  n_pos[1] = am_q.y;  n_pos[2] = am_q.z;
                if (r_i == '0) begin
                    n_lo = n_pos;  n_hi = n_pos;
                end else begin
                    for (int a = 0; a < 3; a++) begin
                        if (n_pos[a] < r_lo[a]) n_lo[a] = n_pos[a];
                        if (n_pos[a] > r_hi[a]) n_hi[a] = n_pos[a];
                    end
                end
                n_i = r_i + ACNT_W'(1);
                if (n_i == r_n) begin
                    n_phase = PH_DIMS;  n_axis = '0;  n_dc = '0;
                    n_state = S_DIV;
                end else begin
                    n_state = S_BB_RD;
                end
            end
            S_DIV: begin
                if (r_dc == '0) begin
                    n_dq = dvd;  n_dr = '0;
                    n_dc = DC_W'(1);
                end else begin
                    n_dr = d_ge ? d_sub[TOL_W-1:0] : d_tmp[TOL_W-1:0];
                    n_dq = {r_dq[COORD_BITS-2:0], d_ge};
                    if (r_dc == DC_W'(DIV_STEPS)) begin
                        n_dc = '0;
                        n_state = S_DIV_DONE;
                    end else begin
                        n_dc = r_dc + DC_W'(1);
                    end
                end
            end
            S_DIV_DONE: begin
                n_axis = r_axis + 2'd1;
                n_state = S_DIV;
                case (r_phase)
                    PH_DIMS: begin
                        n_min[r_axis] = r_lo[r_axis];
                        if (r_dq >= COORD_BITS'(MAX_CELLS)) begin
                            n_st = ST_GRID;
                            n_state = S_EMIT;
                        end else begin
                            n_dim[r_axis] = DIM_W'(r_dq[CELL_W-1:0]) + DIM_W'(1);
                            if (r_axis == 2'd2) n_state = S_TOT1;
                        end
                    end
                    PH_CNT: begin
                        n_cell[r_axis] = r_dq[CELL_W-1:0];
                        if (r_axis == 2'd2) n_state = S_H1;
                    end
                    default: begin
                        n_base[r_axis] = r_dq[CELL_W-1:0];
                        if (r_axis == 2'd2) n_state = S_Q_T2;
                    end
                endcase
            end
            S_TOT1: begin
                n_prod = PROD_W'(r_dim[0]) * PROD_W'(r_dim[1]);
                n_state = S_TOT2;
            end
            S_TOT2: begin
                if (tot > (PROD_W+DIM_W)'(MAX_CELLS)) begin
                    n_st = ST_GRID;
                    n_state = S_EMIT;
                end else begin
                    n_total = tot[CADR_W-1:0];
                    n_pk = '0;
                    n_state = S_CLEAR;
                end
            end
            S_CLEAR: begin
                cs_we = 1'b1;  cs_wa = r_pk;
                n_pk = r_pk + CADR_W'(1);
                if (r_pk == r_total) begin
                    n_i = '0;
                    n_state = S_CNT_RD;
                end
            end
            S_CNT_RD: begin
                n_state = S_CNT_CAP;
            end
            S_CNT_CAP: begin
                n_pos[0] = am_q.x;  n_pos[1] = am_q.y;  n_pos[2] = am_q.z;
                n_phase = PH_CNT;  n_axis = '0;  n_dc = '0;
                n_state = S_DIV;
            end
            S_H1: begin
                n_prod = PROD_W'(r_dim[1]) * PROD_W'(r_cell[2]) + PROD_W'(r_cell[1]);
                n_state = S_H2;
            end
            S_H2: begin
                n_h = hash[CELL_W-1:0];
                n_state = (r_phase == PH_CNT) ? S_CNT_RD2 : S_Q_CS;
            end
            S_CNT_RD2: begin
                cid_we = 1'b1;
                n_state = S_CNT_WR;
            end
            S_CNT_WR: begin
                cs_we = 1'b1;  cs_wa = CADR_W'(r_h) + CADR_W'(1);  cs_wd = cs_qb + ACNT_W'(1);
                n_i = r_i + ACNT_W'(1);
                if (n_i == r_n) begin
                    n_pk = CADR_W'(1);  n_acc = '0;
                    n_state = S_PFX_RD;
                end else begin
                    n_state = S_CNT_RD;
                end
            end
            S_PFX_RD: begin
                cs_ra = r_pk;
                n_state = S_PFX_WR;
            end
            S_PFX_WR: begin
                n_acc = r_acc + cs_qa;
                cs_we = 1'b1;  cs_wa = r_pk;  cs_wd = n_acc;
                fc_we = 1'b1;  fc_wa = CELL_W'(r_pk - CADR_W'(1));  fc_wd = r_acc;
                n_pk = r_pk + CADR_W'(1);
                if (r_pk == r_total) begin
                    n_i = '0;
                    n_state = S_FIL_RD;
                end else begin
                    n_state = S_PFX_RD;
                end
            end
            S_FIL_RD: begin
                n_state = S_FIL_FC;
            end
            S_FIL_FC: begin
                n_h = cid_q;
                n_state = S_FIL_WR;
            end
            S_FIL_WR: begin
                srt_we = 1'b1;
                fc_we = 1'b1;  fc_wa = r_h;  fc_wd = fc_q + ACNT_W'(1);
                n_i = r_i + ACNT_W'(1);
                if (n_i == r_n) begin
                    n_built = 1'b1;  n_st = ST_OK;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_FIL_RD;
                end
            end
            S_Q_RD: begin
                am_ra = r_qi;
                n_state = S_Q_CAP;
            end
            S_Q_CAP: begin
                n_pos[0] = am_q.x;  n_pos[1] = am_q.y;  n_pos[2] = am_q.z;
                n_qbody = am_q.body;
                n_phase = PH_QRY;  n_axis = '0;  n_dc = '0;
                n_state = S_DIV;
            end
            S_Q_T2: begin
                n_t2 = (2*TOL_W)'(t_eff) * (2*TOL_W)'(t_eff);
                for (int a = 0; a < 3; a++) n_d[a] = '0;
                n_pcnt = '0;  n_pv = 1'b0;
                n_state = S_Q_CELL;
            end
            S_Q_CELL: begin
                if (qc_ok) begin
                    for (int a = 0; a < 3; a++) n_cell[a] = qc[a][CELL_W-1:0];
                    n_state = S_H1;
                end else begin
                    n_state = S_Q_NEXT;
                end
            end
            S_Q_NEXT: begin
                n_state = S_Q_CELL;
                if (r_d[2] != 2'd2) begin
                    n_d[2] = r_d[2] + 2'd1;
                end else begin
                    n_d[2] = '0;
                    if (r_d[1] != 2'd2) begin
                        n_d[1] = r_d[1] + 2'd1;
                    end else begin
                        n_d[1] = '0;
                        n_d[0] = r_d[0] + 2'd1;
                        if (r_d[0] == 2'd2) n_state = S_Q_END;
                    end
                end
            end
            S_Q_CS: begin
                cs_ra = CADR_W'(r_h);
                n_state = S_Q_CSD;
            end
            S_Q_CSD: begin
                n_k = cs_qa;  n_kend = cs_qb;
                n_state = S_Q_SCAN;
            end
            S_Q_SCAN: begin
                n_state = (r_k >= r_kend) ? S_Q_NEXT : S_Q_SRT;
            end
            S_Q_SRT: begin
                am_ra = srt_q;
                n_j = srt_q;
                n_state = S_Q_ATM;
            end
            S_Q_ATM: begin
                if (r_j <= r_qi || am_q.body != r_qbody) begin
                    n_k = r_k + ACNT_W'(1);
                    n_state = S_Q_SCAN;
                end else begin
                    for (int a = 0; a < 3; a++) begin
                        n_e[a] = ed[a][DIFF_W-1] ? DIFF_W'(-ed[a]) : DIFF_W'(ed[a]);
                    end
                    n_state = S_Q_D0;
                end
            end
            S_Q_D0: begin
                n_ds = SQ_W'(r_e[0]) * SQ_W'(r_e[0]);
                n_state = S_Q_D1;
            end
            S_Q_D1: begin
                n_ds = r_ds + SQ_W'(r_e[1]) * SQ_W'(r_e[1]);
                n_state = S_Q_D2;
            end
            S_Q_D2: begin
                n_ds = r_ds + SQ_W'(r_e[2]) * SQ_W'(r_e[2]);
                n_state = S_Q_CHK;
            end
            S_Q_CHK: begin
                if (r_ds > SQ_W'(r_t2)) begin
                    n_k = r_k + ACNT_W'(1);
                    n_state = S_Q_SCAN;
                end else if (r_pcnt == PCNT_W'(MAX_PARTNERS)) begin
                    // one partner too many: close out the held beat as truncated
                    if (out_free) begin
                        n_ov = 1'b1;  n_ost = ST_TRUNC;  n_oidx = r_pidx;
                        n_ohp = 1'b1;  n_olast = 1'b1;
                        n_state = S_IDLE;
                    end
                end else if (!r_pv || out_free) begin
                    if (r_pv) begin
                        n_ov = 1'b1;  n_ost = ST_OK;  n_oidx = r_pidx;
                        n_ohp = 1'b1;  n_olast = 1'b0;
                    end
                    n_pv = 1'b1;  n_pidx = r_j;
                    n_pcnt = r_pcnt + PCNT_W'(1);
                    n_k = r_k + ACNT_W'(1);
                    n_state = S_Q_SCAN;
                end
            end
            S_Q_END: begin
                if (out_free) begin
                    n_ov = 1'b1;  n_ost = ST_OK;  n_olast = 1'b1;
                    n_oidx = r_pv ? r_pidx : '0;
                    n_ohp = r_pv;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            n_tol = i_cfg_wdata;
            n_built = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_DIMS;
            r_tol   <= TOL_W'(TOL_RESET);
            r_n     <= '0;
            r_built <= 1'b0;
            r_ov    <= 1'b0;
            r_dc    <= '0;
            r_axis  <= '0;
            r_pv    <= 1'b0;
            r_pcnt  <= '0;
            for (int a = 0; a < 3; a++) begin
                r_min[a] <= '0;
                r_dim[a] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_tol   <= n_tol;
            r_n     <= n_n;
            r_built <= n_built;
            r_ov    <= n_ov;
            r_dc    <= n_dc;
            r_axis  <= n_axis;
            r_pv    <= n_pv;
            r_pcnt  <= n_pcnt;
            r_min   <= n_min;
            r_dim   <= n_dim;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i <= n_i;        r_pk <= n_pk;      r_total <= n_total;  r_acc <= n_acc;
        r_dq <= n_dq;      r_dr <= n_dr;      r_st <= n_st;        r_prod <= n_prod;
        r_h <= n_h;        r_qi <= n_qi;      r_qbody <= n_qbody;  r_j <= n_j;
        r_k <= n_k;        r_kend <= n_kend;  r_t2 <= n_t2;        r_ds <= n_ds;
        r_pidx <= n_pidx;
        r_lo <= n_lo;  r_hi <= n_hi;  r_pos <= n_pos;  r_cell <= n_cell;
        r_base <= n_base;  r_e <= n_e;  r_d <= n_d;
        r_ost <= n_ost;  r_oidx <= n_oidx;  r_ohp <= n_ohp;  r_olast <= n_olast;
    end

    // memories, registered reads
    always_ff @(posedge i_clk) begin
        if (am_we) atom_mem[r_n[AIDX_W-1:0]] <= am_wd;
        am_q <= atom_mem[am_ra];
    end

    always_ff @(posedge i_clk) begin
        if (cid_we) cid_mem[r_i[AIDX_W-1:0]] <= r_h;
        cid_q <= cid_mem[r_i[AIDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (cs_we) cs_mem[cs_wa] <= cs_wd;
        cs_qa <= cs_mem[cs_ra];
        cs_qb <= cs_mem[CADR_W'(r_h) + CADR_W'(1)];
    end

    always_ff @(posedge i_clk) begin
        if (fc_we) fc_mem[fc_wa] <= fc_wd;
        fc_q <= fc_mem[cid_q];
    end

    always_ff @(posedge i_clk) begin
        if (srt_we) srt_mem[fc_q[AIDX_W-1:0]] <= r_i[AIDX_W-1:0];
        srt_q <= srt_mem[r_k[AIDX_W-1:0]];
    end

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Exercises cell_list_bond_finder_unit. Commands go out in random bursts and
// result beats are taken under a shifting stall pattern. Each result is
// checked against a behavioral copy of the grid builder and partner search.
// ----------------------------------------------------------------------------
module testbench;
    import clbf_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [AIDX_W-1:0] partner;
        logic              has_partner;
        logic              last;
    } bond_res_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [TOL_W-1:0] cfg_wdata;

    clbf_in_if  cmd_if ();
    clbf_res_if res_if ();

    cell_list_bond_finder_unit uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (cmd_if.sink),
        .o_res       (res_if.source)
    );

    // shadow of the block state
    longint      atom_x [MAX_ATOMS];
    longint      atom_y [MAX_ATOMS];
    longint      atom_z [MAX_ATOMS];
    int unsigned atom_body [MAX_ATOMS];
    int          atom_count;
    longint      box_lo [3];
    longint      dims [3];
    int          cell_first [MAX_CELLS+1];
    int          cell_fill [MAX_CELLS];
    int          binned_atoms [MAX_ATOMS];
    bit          grid_ready;
    int unsigned tol_reg;

    bond_res_t   expected_q [$];
    int          errors;
    int          cmds_sent;
    int          burst_left;
    int unsigned cyc;

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic longint cell_edge();
        return (tol_reg == 0) ? 64'd1 : longint'(tol_reg);
    endfunction

    function automatic longint axis_bin(longint c, int a);
        return (c - box_lo[a]) / cell_edge();
    endfunction

    function automatic longint home_cell(int i);
        return axis_bin(atom_x[i], 0)
             + dims[0] * (axis_bin(atom_y[i], 1) + dims[1] * axis_bin(atom_z[i], 2));
    endfunction

    function automatic t_status build_grid();
        longint lo [3];
        longint hi [3];
        longint p [3];
        longint total;
        longint h;
        grid_ready = 1'b0;
        if (atom_count == 0) begin
            for (int a = 0; a < 3; a++) begin
                box_lo[a] = 0;
                dims[a]   = 1;
            end
            cell_first[0] = 0;
            cell_first[1] = 0;
            grid_ready = 1'b1;
            return ST_OK;
        end
        lo[0] = atom_x[0]; lo[1] = atom_y[0]; lo[2] = atom_z[0];
        hi = lo;
        for (int i = 1; i < atom_count; i++) begin
            p[0] = atom_x[i]; p[1] = atom_y[i]; p[2] = atom_z[i];
            for (int a = 0; a < 3; a++) begin
                if (p[a] < lo[a]) lo[a] = p[a];
                if (p[a] > hi[a]) hi[a] = p[a];
            end
        end
        for (int a = 0; a < 3; a++) begin
            box_lo[a] = lo[a];
            dims[a]   = (hi[a] - lo[a]) / cell_edge() + 1;
            if (dims[a] > MAX_CELLS) return ST_GRID;
        end
        total = dims[0] * dims[1] * dims[2];
        if (total > MAX_CELLS) return ST_GRID;
        for (int c = 0; c <= MAX_CELLS; c++) cell_first[c] = 0;
        for (int i = 0; i < atom_count; i++) cell_first[home_cell(i) + 1]++;
        for (int c = 0; c < total; c++) cell_first[c+1] += cell_first[c];
        for (int c = 0; c < total; c++) cell_fill[c] = cell_first[c];
        for (int i = 0; i < atom_count; i++) begin
            h = home_cell(i);
            binned_atoms[cell_fill[h]] = i;
            cell_fill[h]++;
        end
        grid_ready = 1'b1;
        return ST_OK;
    endfunction

    task automatic push_result(t_status st, int idx, bit hp, bit lst);
        bond_res_t r;
        r.status      = st;
        r.partner     = idx[AIDX_W-1:0];
        r.has_partner = hp;
        r.last        = lst;
        expected_q.push_back(r);
    endtask

    task automatic find_partners(int qi);
        longint t2, ex, ey, ez, h;
        longint base [3];
        longint c [3];
        int     j;
        bit     trunc;
        int     found [$];
        t2 = cell_edge() * cell_edge();
        base[0] = axis_bin(atom_x[qi], 0);
        base[1] = axis_bin(atom_y[qi], 1);
        base[2] = axis_bin(atom_z[qi], 2);
        trunc = 1'b0;
        for (int dx = -1; dx <= 1 && !trunc; dx++)
            for (int dy = -1; dy <= 1 && !trunc; dy++)
                for (int dz = -1; dz <= 1 && !trunc; dz++) begin
                    c[0] = base[0] + dx; c[1] = base[1] + dy; c[2] = base[2] + dz;
                    if (c[0] < 0 || c[1] < 0 || c[2] < 0) continue;
                    if (c[0] >= dims[0] || c[1] >= dims[1] || c[2] >= dims[2]) continue;
                    h = c[0] + dims[0] * (c[1] + dims[1] * c[2]);
                    for (int k = cell_first[h]; k < cell_first[h+1]; k++) begin
                        j = binned_atoms[k];
                        if (j <= qi || atom_body[j] != atom_body[qi]) continue;
                        ex = atom_x[j] - atom_x[qi];
                        ey = atom_y[j] - atom_y[qi];
                        ez = atom_z[j] - atom_z[qi];
                        if (ex*ex + ey*ey + ez*ez > t2) continue;
                        if (found.size() >= MAX_PARTNERS) begin
                            trunc = 1'b1;
                            break;
                        end
                        found.push_back(j);
                    end
                end
        if (found.size() == 0) begin
            push_result(ST_OK, 0, 1'b0, 1'b1);
        end else begin
            for (int n = 0; n < found.size(); n++) begin
                if (n == found.size() - 1)
                    push_result(trunc ? ST_TRUNC : ST_OK, found[n], 1'b1, 1'b1);
                else
                    push_result(ST_OK, found[n], 1'b1, 1'b0);
            end
        end
    endtask

    task automatic predict_cmd(t_op op, logic signed [COORD_BITS-1:0] x,
                               logic signed [COORD_BITS-1:0] y,
                               logic signed [COORD_BITS-1:0] z,
                               logic [BODY_W-1:0] body, logic [AIDX_W-1:0] idx);
        case (op)
            OP_CLEAR: begin
                atom_count = 0;
                grid_ready = 1'b0;
                push_result(ST_OK, 0, 1'b0, 1'b1);
            end
            OP_LOAD: begin
                grid_ready = 1'b0;
                if (atom_count >= MAX_ATOMS) begin
                    push_result(ST_FULL, 0, 1'b0, 1'b1);
                end else begin
                    atom_x[atom_count]    = x;
                    atom_y[atom_count]    = y;
                    atom_z[atom_count]    = z;
                    atom_body[atom_count] = body;
                    atom_count++;
                    push_result(ST_OK, 0, 1'b0, 1'b1);
                end
            end
            OP_BUILD: push_result(build_grid(), 0, 1'b0, 1'b1);
            default: begin
                if (!grid_ready)
                    push_result(ST_NOTBUILT, 0, 1'b0, 1'b1);
                else if (int'(idx) >= atom_count)
                    push_result(ST_BADIDX, 0, 1'b0, 1'b1);
                else
                    find_partners(int'(idx));
            end
        endcase
    endtask

    task automatic send_cmd(t_op op, int x = 0, int y = 0, int z = 0,
                            int body = 0, int idx = 0);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0) begin
                cmd_if.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
        burst_left--;
        cmd_if.opcode     <= op;
        cmd_if.x_coord    <= x[COORD_BITS-1:0];
        cmd_if.y_coord    <= y[COORD_BITS-1:0];
        cmd_if.z_coord    <= z[COORD_BITS-1:0];
        cmd_if.body_id    <= body[BODY_W-1:0];
        cmd_if.atom_index <= idx[AIDX_W-1:0];
        cmd_if.valid      <= 1'b1;
        @(posedge clk);
        while (!cmd_if.ready) @(posedge clk);
        cmds_sent++;
        predict_cmd(op, x[COORD_BITS-1:0], y[COORD_BITS-1:0], z[COORD_BITS-1:0],
                    body[BODY_W-1:0], idx[AIDX_W-1:0]);
    endtask

    // hold off until every pending result beat is back
    task automatic drain();
        cmd_if.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_tolerance(int unsigned v);
        drain();
        cfg_wdata <= v[TOL_W-1:0];
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        tol_reg    = v[TOL_W-1:0];
        grid_ready = 1'b0;
    endtask

    task automatic random_load(int unsigned spread, int body);
        int base [3];
        int lim;
        lim = 16777215 - int'(spread);
        for (int a = 0; a < 3; a++) base[a] = int'($urandom_range(0, lim)) - 8388608;
        send_cmd(OP_LOAD, base[0] + int'($urandom_range(0, spread)),
                 base[1] + int'($urandom_range(0, spread)),
                 base[2] + int'($urandom_range(0, spread)), body, $urandom_range(0, 1023));
    endtask

    task automatic test_directed();
        send_cmd(OP_QUERY, 0, 0, 0, 0, 0);
        send_cmd(OP_BUILD);
        send_cmd(OP_QUERY, 0, 0, 0, 0, 0);
        send_cmd(OP_LOAD, -8388608, -8388608, -8388608, 0, 1023);
        send_cmd(OP_LOAD, 8388607, 8388607, 8388607, 65535, 0);
        send_cmd(OP_BUILD);            // span far beyond the cell limit
        send_cmd(OP_QUERY, 0, 0, 0, 0, 0);
        send_cmd(OP_CLEAR);
        send_cmd(OP_LOAD, 0, 0, 0, 3);
        send_cmd(OP_LOAD, 100, 100, 100, 3);
        send_cmd(OP_LOAD, 256, 0, 0, 3);
        send_cmd(OP_LOAD, 10, 10, 10, 4);
        send_cmd(OP_LOAD, -200, 50, -30, 3);
        send_cmd(OP_BUILD);
        send_cmd(OP_QUERY, 0, 0, 0, 0, 0);
        send_cmd(OP_QUERY, 0, 0, 0, 0, 1);
        send_cmd(OP_QUERY, 0, 0, 0, 0, 4);
        send_cmd(OP_QUERY, 0, 0, 0, 0, 5);
        send_cmd(OP_QUERY, 0, 0, 0, 0, 1023);
    endtask

    task automatic test_tolerance_extremes();
        set_tolerance(0);
        send_cmd(OP_CLEAR);
        send_cmd(OP_LOAD, 0, 0, 0, 5);
        send_cmd(OP_LOAD, 1, 0, 0, 5);
        send_cmd(OP_LOAD, 1, 1, 0, 5);
        send_cmd(OP_BUILD);
        send_cmd(OP_QUERY, 0, 0, 0, 0, 0);
        send_cmd(OP_QUERY, 0, 0, 0, 0, 1);
        set_tolerance(8388607);
        send_cmd(OP_CLEAR);
        send_cmd(OP_LOAD, -8388608, -8388608, -8388608, 9);
        send_cmd(OP_LOAD, 8388607, 8388607, 8388607, 9);
        send_cmd(OP_LOAD, 0, 0, 0, 9);
        send_cmd(OP_LOAD, -4000000, 100, 3000000, 9);
        send_cmd(OP_BUILD);
        send_cmd(OP_QUERY, 0, 0, 0, 0, 0);
        send_cmd(OP_QUERY, 0, 0, 0, 0, 2);
        set_tolerance(1);
        send_cmd(OP_BUILD);
        send_cmd(OP_QUERY, 0, 0, 0, 0, 0);
    endtask

    task automatic test_truncation();
        set_tolerance(256);
        send_cmd(OP_CLEAR);
        for (int i = 0; i < 20; i++)
            send_cmd(OP_LOAD, $urandom_range(0, 50), $urandom_range(0, 50),
                     $urandom_range(0, 50), 7);
        send_cmd(OP_BUILD);
        send_cmd(OP_QUERY, 0, 0, 0, 0, 0);
        send_cmd(OP_QUERY, 0, 0, 0, 0, 3);    // exactly sixteen later partners
        send_cmd(OP_QUERY, 0, 0, 0, 0, 18);
    endtask

    task automatic test_dense_build();
        send_cmd(OP_CLEAR);
        for (int i = 0; i < 60; i++)
            send_cmd(OP_LOAD, (i % 4) * 256 + $urandom_range(0, 200),
                     ((i / 4) % 4) * 256 + $urandom_range(0, 200),
                     (i / 16) * 256 + $urandom_range(0, 200), $urandom_range(0, 3));
        send_cmd(OP_BUILD);
        for (int i = 0; i < 6; i++) send_cmd(OP_QUERY, 0, 0, 0, 0, $urandom_range(0, 59));
        send_cmd(OP_QUERY, 0, 0, 0, 0, 59);
        drain();
    endtask

    task automatic test_random();
        int          n, kind, start;
        int unsigned spread, pick;
        start = cmds_sent;
        while (cmds_sent - start < 150) begin
            if ($urandom_range(0, 5) == 0) begin
                pick = $urandom_range(0, 4);
                case (pick)
                    0: set_tolerance(1);
                    1: set_tolerance(8388607);
                    2: set_tolerance(256);
                    3: set_tolerance($urandom_range(2, 2000));
                    default: set_tolerance($urandom_range(1, 8388607));
                endcase
            end
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                repeat ($urandom_range(1, 3))
                    send_cmd(t_op'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
                             $urandom_range(0, 65535), $urandom_range(0, 1023));
            end else begin
                send_cmd(OP_CLEAR);
                n = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(1, 14);
                spread = 32'(cell_edge() * $urandom_range(1, 4));
                if (spread > 8388607) spread = 8388607;
                for (int i = 0; i < n; i++)
                    random_load(spread, ($urandom_range(0, 9) == 0) ?
                                $urandom_range(0, 65535) : $urandom_range(0, 1));
                if (kind != 1) send_cmd(OP_BUILD);
                repeat ($urandom_range(2, 6))
                    send_cmd(OP_QUERY, $urandom, $urandom, $urandom, $urandom_range(0, 65535),
                             ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023)
                                                          : $urandom_range(0, n - 1));
            end
        end
    endtask

    // result beats: the stall pattern follows bits 9:8 of the cycle counter
    always @(posedge clk) begin
        cyc <= cyc + 1;
        case (cyc[9:8])
            2'd0: res_if.ready <= 1'b1;
            2'd1: res_if.ready <= $urandom_range(0, 1);
            2'd2: res_if.ready <= (cyc % 7) < 3;
            default: res_if.ready <= ($urandom_range(0, 7) != 0);
        endcase
        if (cyc > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge clk) begin
        bond_res_t want;
        if (rst_n && res_if.valid && res_if.ready) begin
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected beat status=%0d partner=%0d has=%0b last=%0b",
                         $realtime, res_if.status, res_if.partner_index,
                         res_if.has_partner, res_if.last);
            end else begin
                want = expected_q.pop_front();
                if (res_if.status !== want.status) begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d", $realtime,
                             want.status, res_if.status);
                end
                if (res_if.partner_index !== want.partner) begin
                    errors++;
                    $display("%0t: partner_index expected %0d actual %0d", $realtime,
                             want.partner, res_if.partner_index);
                end
                if (res_if.has_partner !== want.has_partner) begin
                    errors++;
                    $display("%0t: has_partner expected %0b actual %0b", $realtime,
                             want.has_partner, res_if.has_partner);
                end
                if (res_if.last !== want.last) begin
                    errors++;
                    $display("%0t: last expected %0b actual %0b", $realtime,
                             want.last, res_if.last);
                end
            end
        end
    end

    initial begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = '0;
        cmd_if.valid      = 1'b0;
        cmd_if.opcode     = OP_CLEAR;
        cmd_if.x_coord    = '0;
        cmd_if.y_coord    = '0;
        cmd_if.z_coord    = '0;
        cmd_if.body_id    = '0;
        cmd_if.atom_index = '0;
        res_if.ready      = 1'b0;
        cyc               = 0;
        errors            = 0;
        cmds_sent         = 0;
        burst_left        = 0;
        atom_count        = 0;
        grid_ready        = 1'b0;
        tol_reg           = TOL_RESET;
        for (int a = 0; a < 3; a++) begin
            box_lo[a] = 0;
            dims[a]   = 0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_tolerance_extremes();
        test_truncation();
        test_dense_build();
        test_random();
        drain();
        repeat (50) @(posedge clk);

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ cell_list_bond_finder_unit.f @@
hdl/clbf_pkg.sv
hdl/clbf_if.sv
hdl/cell_list_bond_finder_unit.sv
sim/testbench.sv
